>>> design/matinv_pkg.sv
// matinv_pkg: request/result types and fixed widths for the 3x3 matrix inverse.
// No dependencies; used by every module of the block.
package matinv_pkg;

  localparam int unsigned ENT_W  = 32;  // Q16.16 entry width
  localparam int unsigned CM_W   = 64;  // cofactor magnitude width
  localparam int unsigned DM_W   = 96;  // determinant magnitude width
  localparam int unsigned N_LANE = 9;   // one lane per adjugate entry
  localparam int unsigned N_DET  = 3;   // first-row expansion terms
  localparam int unsigned Q_STEPS = 32; // quotient bits, one per stage

  typedef struct packed {
    logic signed [ENT_W-1:0] a11;
    logic signed [ENT_W-1:0] a12;
    logic signed [ENT_W-1:0] a13;
    logic signed [ENT_W-1:0] a21;
    logic signed [ENT_W-1:0] a22;
    logic signed [ENT_W-1:0] a23;
    logic signed [ENT_W-1:0] a31;
    logic signed [ENT_W-1:0] a32;
    logic signed [ENT_W-1:0] a33;
  } in_req_t;

  typedef struct packed {
    logic signed [ENT_W-1:0] b11;
    logic signed [ENT_W-1:0] b12;
    logic signed [ENT_W-1:0] b13;
    logic signed [ENT_W-1:0] b21;
    logic signed [ENT_W-1:0] b22;
    logic signed [ENT_W-1:0] b23;
    logic signed [ENT_W-1:0] b31;
    logic signed [ENT_W-1:0] b32;
    logic signed [ENT_W-1:0] b33;
    logic                    singular;
  } out_res_t;

endpackage

>>> design/matinv_cof_lane.sv
// matinv_cof_lane: one cofactor x*y - z*w, exact, as magnitude and sign.
// Depends on matinv_pkg. Products, difference and magnitude are registered in turn; one request per cycle.
module matinv_cof_lane
  import matinv_pkg::*;
(
  input  logic                    clk,
  input  logic signed [ENT_W-1:0] x,
  input  logic signed [ENT_W-1:0] y,
  input  logic signed [ENT_W-1:0] z,
  input  logic signed [ENT_W-1:0] w,
  output logic        [CM_W-1:0]  cm,
  output logic                    cneg
);

  logic signed [2*ENT_W-1:0] pxy_r, pzw_r;
  logic signed [2*ENT_W:0]   c_r;
  logic        [CM_W-1:0]    cm_r;
  logic                      cneg_r;
  logic signed [2*ENT_W:0]   c_abs;

  // two products in parallel
  always_ff @(posedge clk) begin
    pxy_r <= x * y;
    pzw_r <= z * w;
  end

  // difference, one extra bit
  always_ff @(posedge clk) begin
    c_r <= {pxy_r[2*ENT_W-1], pxy_r} - {pzw_r[2*ENT_W-1], pzw_r};
  end

  // magnitude fits 64 bits unsigned (at most 2^63)
  assign c_abs = c_r[2*ENT_W] ? -c_r : c_r;

  always_ff @(posedge clk) begin
    cm_r   <= c_abs[CM_W-1:0];
    cneg_r <= c_r[2*ENT_W];
  end

  assign cm   = cm_r;
  assign cneg = cneg_r;

endmodule

>>> design/matinv_det.sv
// matinv_det: merges three first-row cofactors into the determinant.
// Depends on matinv_pkg. Takes row entries at acceptance and holds them until the cofactors arrive;
// products, recombined terms, signed terms, sum and magnitude, sign and zero flag are registered in turn.
module matinv_det
  import matinv_pkg::*;
(
  input  logic                              clk,
  input  logic [N_DET-1:0][ENT_W-1:0]       row,
  input  logic [N_DET-1:0][CM_W-1:0]        cm,
  input  logic [N_DET-1:0]                  cneg,
  output logic [DM_W-1:0]                   dmag,
  output logic                              dneg,
  output logic                              dzero
);

  localparam int unsigned A_DLY = 3;

  logic [N_DET-1:0][ENT_W-1:0] am_r   [A_DLY];
  logic [N_DET-1:0]            asgn_r [A_DLY];
  logic [N_DET-1:0][ENT_W-1:0] am_w;
  logic [N_DET-1:0][2*ENT_W-1:0] plo_r, phi_r;
  logic [N_DET-1:0]            sneg_r, sneg2_r;
  logic [N_DET-1:0][DM_W-1:0]  term_r;
  logic signed [DM_W:0]        sterm_r [N_DET];
  logic signed [DM_W+1:0]      sum_r;
  logic signed [DM_W+1:0]      sum_abs;
  logic [DM_W-1:0]             dmag_r;
  logic                        dneg_r, dzero_r;

  // entry magnitudes, held until the cofactors arrive
  always_comb begin
    for (int i = 0; i < N_DET; i++) begin
      am_w[i] = row[i][ENT_W-1] ? ENT_W'(-row[i]) : row[i];
    end
  end

  always_ff @(posedge clk) begin
    am_r[0] <= am_w;
    for (int i = 0; i < N_DET; i++) asgn_r[0][i] <= row[i][ENT_W-1];
    for (int k = 1; k < A_DLY; k++) begin
      am_r[k]   <= am_r[k-1];
      asgn_r[k] <= asgn_r[k-1];
    end
  end

  // 64x32 product as two 32x32 halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_DET; i++) begin
      plo_r[i]  <= (2*ENT_W)'(cm[i][ENT_W-1:0]) * (2*ENT_W)'(am_r[A_DLY-1][i]);
      phi_r[i]  <= (2*ENT_W)'(cm[i][CM_W-1:ENT_W]) * (2*ENT_W)'(am_r[A_DLY-1][i]);
      sneg_r[i] <= asgn_r[A_DLY-1][i] ^ cneg[i];
    end
  end

  // recombine halves
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_DET; i++) begin
      term_r[i]  <= DM_W'(plo_r[i]) + {phi_r[i], {ENT_W{1'b0}}};
      sneg2_r[i] <= sneg_r[i];
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    for (int i = 0; i < N_DET; i++) begin
      sterm_r[i] <= sneg2_r[i] ? -$signed({1'b0, term_r[i]}) : $signed({1'b0, term_r[i]});
    end
  end

  // sum of the three terms
  always_ff @(posedge clk) begin
    sum_r <= (DM_W+2)'(sterm_r[0]) + (DM_W+2)'(sterm_r[1]) + (DM_W+2)'(sterm_r[2]);
  end

  assign sum_abs = sum_r[DM_W+1] ? -sum_r : sum_r;

  always_ff @(posedge clk) begin
    dmag_r  <= sum_abs[DM_W-1:0];
    dneg_r  <= sum_r[DM_W+1];
    dzero_r <= (sum_r == '0);
  end

  assign dmag  = dmag_r;
  assign dneg  = dneg_r;
  assign dzero = dzero_r;

endmodule

>>> design/matinv_div_lane.sv
// matinv_div_lane: (cm * 2^32) / dmag, one quotient bit per stage, saturated.
// Depends on matinv_pkg. Entry, quotient-bit stages and saturated output are registered in turn; one request per cycle.
module matinv_div_lane
  import matinv_pkg::*;
(
  input  logic                            clk,
  input  logic [CM_W-1:0]                 cm,
  input  logic                            cneg,
  input  logic                            dneg,
  input  logic [DM_W-1:0]                 dmag,
  input  logic [Q_STEPS-1:0][DM_W-1:0]    dmag_line,
  input  logic                            zero,
  output logic signed [ENT_W-1:0]         b
);

  logic [DM_W-1:0]    rem_r [Q_STEPS+1];
  logic [ENT_W-1:0]   q_r   [Q_STEPS+1];
  logic               neg_r [Q_STEPS+1];
  logic               ovf_r [Q_STEPS+1];
  logic signed [ENT_W-1:0] b_r;
  logic [ENT_W-1:0]   limit, mag;

  // entry: quotient reaches 2^32 exactly when cm >= dmag
  always_ff @(posedge clk) begin
    rem_r[0] <= DM_W'(cm);
    q_r[0]   <= '0;
    neg_r[0] <= cneg ^ dneg;
    ovf_r[0] <= (DM_W'(cm) >= dmag);
  end

  // restoring steps, zeros shifted in
  for (genvar k = 0; k < Q_STEPS; k++) begin : g_step
    logic [DM_W:0] rem2;
    logic          take;
    assign rem2 = {rem_r[k], 1'b0};
    assign take = (rem2 >= {1'b0, dmag_line[k]});
    always_ff @(posedge clk) begin
      rem_r[k+1] <= take ? DM_W'(rem2 - {1'b0, dmag_line[k]}) : rem2[DM_W-1:0];
      q_r[k+1]   <= {q_r[k][ENT_W-2:0], take};
      neg_r[k+1] <= neg_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  // saturate, sign, force zero when singular
  assign limit = neg_r[Q_STEPS] ? {1'b1, {(ENT_W-1){1'b0}}} : {1'b0, {(ENT_W-1){1'b1}}};
  assign mag   = (ovf_r[Q_STEPS] || q_r[Q_STEPS] > limit) ? limit : q_r[Q_STEPS];

  always_ff @(posedge clk) begin
    if (zero) begin
      b_r <= '0;
    end else begin
      b_r <= neg_r[Q_STEPS] ? $signed(-mag) : $signed(mag);
    end
  end

  assign b = b_r;

endmodule

>>> design/matrix3x3_inverse_top.sv
// matrix3x3_inverse_top: 3x3 Q16.16 matrix inverse by adjugate over determinant.
// Depends on matinv_pkg, matinv_cof_lane, matinv_det, matinv_div_lane.
//
//  channel | ports                 | handshake
//  --------+-----------------------+-------------------------------------
//  request | start, busy, in_req   | taken when start high and busy low
//  result  | out_valid, out_res    | one-cycle strobe, cannot be held off
//
// One request per cycle; busy is always low. Each result passes in order through
// the cofactor lanes, the determinant merge, 1 divider entry stage,
// 32 quotient-bit stages and 1 saturation stage.
// Synchronous active-low reset clears only the valid pipeline.
module matrix3x3_inverse_top
  import matinv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_res_t out_res
);

  localparam int unsigned LAT    = 42;
  localparam int unsigned CM_DLY = 5;
  localparam int unsigned Z_DLY  = Q_STEPS + 2;

  logic                           accept;
  logic [LAT-1:0]                 vld_r;
  logic [N_LANE-1:0][ENT_W-1:0]   opx, opy, opz, opw;
  logic [N_LANE-1:0][CM_W-1:0]    cm_w;
  logic [N_LANE-1:0]              cneg_w;
  logic [N_LANE-1:0][CM_W-1:0]    cm_d_r   [CM_DLY];
  logic [N_LANE-1:0]              cneg_d_r [CM_DLY];
  logic [DM_W-1:0]                dmag;
  logic                           dneg, dzero;
  logic [Q_STEPS-1:0][DM_W-1:0]   dline_r;
  logic [Z_DLY-1:0]               z_r;
  logic [N_LANE-1:0][ENT_W-1:0]   b_w;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // cofactor operands: lane i gives adjugate entry i, row-major
  always_comb begin
    opx[0] = in_req.a22; opy[0] = in_req.a33; opz[0] = in_req.a23; opw[0] = in_req.a32;
    opx[1] = in_req.a13; opy[1] = in_req.a32; opz[1] = in_req.a12; opw[1] = in_req.a33;
    opx[2] = in_req.a12; opy[2] = in_req.a23; opz[2] = in_req.a13; opw[2] = in_req.a22;
    opx[3] = in_req.a23; opy[3] = in_req.a31; opz[3] = in_req.a21; opw[3] = in_req.a33;
    opx[4] = in_req.a11; opy[4] = in_req.a33; opz[4] = in_req.a13; opw[4] = in_req.a31;
    opx[5] = in_req.a13; opy[5] = in_req.a21; opz[5] = in_req.a11; opw[5] = in_req.a23;
    opx[6] = in_req.a21; opy[6] = in_req.a32; opz[6] = in_req.a22; opw[6] = in_req.a31;
    opx[7] = in_req.a12; opy[7] = in_req.a31; opz[7] = in_req.a11; opw[7] = in_req.a32;
    opx[8] = in_req.a11; opy[8] = in_req.a22; opz[8] = in_req.a12; opw[8] = in_req.a21;
  end

  for (genvar i = 0; i < N_LANE; i++) begin : g_cof
    matinv_cof_lane u_cof (
      .clk  (clk),
      .x    (opx[i]),
      .y    (opy[i]),
      .z    (opz[i]),
      .w    (opw[i]),
      .cm   (cm_w[i]),
      .cneg (cneg_w[i])
    );
  end

  // determinant from first row: a11*C11 + a12*C12 + a13*C13
  matinv_det u_det (
    .clk   (clk),
    .row   ({in_req.a13, in_req.a12, in_req.a11}),
    .cm    ({cm_w[6], cm_w[3], cm_w[0]}),
    .cneg  ({cneg_w[6], cneg_w[3], cneg_w[0]}),
    .dmag  (dmag),
    .dneg  (dneg),
    .dzero (dzero)
  );

  // hold cofactors until the determinant is ready
  always_ff @(posedge clk) begin
    cm_d_r[0]   <= cm_w;
    cneg_d_r[0] <= cneg_w;
    for (int k = 1; k < CM_DLY; k++) begin
      cm_d_r[k]   <= cm_d_r[k-1];
      cneg_d_r[k] <= cneg_d_r[k-1];
    end
  end

  // divisor and singular flag follow the divider stages
  always_ff @(posedge clk) begin
    dline_r <= {dline_r[Q_STEPS-2:0], dmag};
    z_r     <= {z_r[Z_DLY-2:0], dzero};
  end

  for (genvar i = 0; i < N_LANE; i++) begin : g_div
    matinv_div_lane u_div (
      .clk       (clk),
      .cm        (cm_d_r[CM_DLY-1][i]),
      .cneg      (cneg_d_r[CM_DLY-1][i]),
      .dneg      (dneg),
      .dmag      (dmag),
      .dmag_line (dline_r),
      .zero      (z_r[Z_DLY-2]),
      .b         (b_w[i])
    );
  end

  assign out_valid        = vld_r[LAT-1];
  assign out_res.b11      = b_w[0];
  assign out_res.b12      = b_w[1];
  assign out_res.b13      = b_w[2];
  assign out_res.b21      = b_w[3];
  assign out_res.b22      = b_w[4];
  assign out_res.b23      = b_w[5];
  assign out_res.b31      = b_w[6];
  assign out_res.b32      = b_w[7];
  assign out_res.b33      = b_w[8];
  assign out_res.singular = z_r[Z_DLY-1];

endmodule
